// File: sv/fvcw_pkg.sv
`timescale 1ns / 1ps

package fvcw_pkg;

    // Number format and wheel size
    localparam int FRAC_BITS  = 14;
    localparam int WHEEL_SIZE = 55;
    localparam int POS_FRAC   = 16;
    localparam int IN_W       = 16;
    localparam int CH_W       = 8;

    // Derived widths
    localparam int MAG_W   = IN_W;                   // |component|, up to 2^(IN_W-1)
    localparam int D_W     = IN_W + 1;               // |x| + |y|, also divider remainder
    localparam int T_W     = D_W + 2;                // wheel numerator, up to 4*D
    localparam int RAD_W   = FRAC_BITS + 1;          // radius when inside the unit circle
    localparam int WIDX_W  = $clog2(WHEEL_SIZE);
    localparam int Q_W     = WIDX_W + POS_FRAC;      // wheel position, Q.POS_FRAC
    localparam int N_W     = D_W + Q_W;              // dividend width
    localparam int SCALE_W = N_W - (POS_FRAC - 2);   // (WHEEL_SIZE-1) * t
    localparam int CQ_W    = CH_W + POS_FRAC;        // interpolated channel, Q.POS_FRAC
    localparam int PROD_W  = RAD_W + CQ_W;           // radius blend product

    localparam logic [MAG_W-1:0] ONE     = MAG_W'(1 << FRAC_BITS);
    localparam logic [Q_W-1:0]   MID_POS = Q_W'(((WHEEL_SIZE - 1) << POS_FRAC) >> 1);
    localparam logic [Q_W-1:0]   MAX_POS = Q_W'((WHEEL_SIZE - 1) << POS_FRAC);
    localparam logic [CQ_W-1:0]  WHITE   = CQ_W'(255 << POS_FRAC);

    // Input and output transactions
    typedef struct packed {
        logic signed [IN_W-1:0] flow_x;
        logic signed [IN_W-1:0] flow_y;
    } vec_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pix_t;

    // Divider lane: running remainder, dividend bits shifting into quotient bits
    typedef struct packed {
        logic [D_W-1:0]   rem;
        logic [Q_W-1:0]   bits;
        logic [D_W-1:0]   den;
        logic [RAD_W-1:0] rad;
        logic             near;
        logic             zero;
    } div_t;

    // Wheel color, [2] red, [1] green, [0] blue
    typedef logic [2:0][CH_W-1:0] color_t;

    localparam color_t WHEEL_ROM [WHEEL_SIZE] = '{
        {8'd255, 8'd0,   8'd0},   {8'd255, 8'd17,  8'd0},   {8'd255, 8'd34,  8'd0},
        {8'd255, 8'd51,  8'd0},   {8'd255, 8'd68,  8'd0},   {8'd255, 8'd85,  8'd0},
        {8'd255, 8'd102, 8'd0},   {8'd255, 8'd119, 8'd0},   {8'd255, 8'd136, 8'd0},
        {8'd255, 8'd153, 8'd0},   {8'd255, 8'd170, 8'd0},   {8'd255, 8'd187, 8'd0},
        {8'd255, 8'd204, 8'd0},   {8'd255, 8'd221, 8'd0},   {8'd255, 8'd238, 8'd0},
        {8'd255, 8'd255, 8'd0},   {8'd213, 8'd255, 8'd0},   {8'd170, 8'd255, 8'd0},
        {8'd128, 8'd255, 8'd0},   {8'd85,  8'd255, 8'd0},   {8'd43,  8'd255, 8'd0},
        {8'd0,   8'd255, 8'd0},   {8'd0,   8'd255, 8'd63},  {8'd0,   8'd255, 8'd127},
        {8'd0,   8'd255, 8'd191}, {8'd0,   8'd255, 8'd255}, {8'd0,   8'd232, 8'd255},
        {8'd0,   8'd209, 8'd255}, {8'd0,   8'd186, 8'd255}, {8'd0,   8'd163, 8'd255},
        {8'd0,   8'd140, 8'd255}, {8'd0,   8'd116, 8'd255}, {8'd0,   8'd93,  8'd255},
        {8'd0,   8'd70,  8'd255}, {8'd0,   8'd47,  8'd255}, {8'd0,   8'd24,  8'd255},
        {8'd0,   8'd0,   8'd255}, {8'd19,  8'd0,   8'd255}, {8'd39,  8'd0,   8'd255},
        {8'd58,  8'd0,   8'd255}, {8'd78,  8'd0,   8'd255}, {8'd98,  8'd0,   8'd255},
        {8'd117, 8'd0,   8'd255}, {8'd137, 8'd0,   8'd255}, {8'd156, 8'd0,   8'd255},
        {8'd176, 8'd0,   8'd255}, {8'd196, 8'd0,   8'd255}, {8'd215, 8'd0,   8'd255},
        {8'd235, 8'd0,   8'd255}, {8'd255, 8'd0,   8'd255}, {8'd255, 8'd0,   8'd213},
        {8'd255, 8'd0,   8'd170}, {8'd255, 8'd0,   8'd128}, {8'd255, 8'd0,   8'd85},
        {8'd255, 8'd0,   8'd43}
    };

    // Read the wheel, holding any index past the table at the last entry
    function automatic color_t wheel_color(input logic [WIDX_W-1:0] idx);
        color_t c;
        if (idx < WIDX_W'(WHEEL_SIZE))
        begin
            c = WHEEL_ROM[idx];
        end
        else
        begin
            c = WHEEL_ROM[WHEEL_SIZE-1];
        end
        return c;
    endfunction

endpackage

// File: sv/fvcw_front.sv
`timescale 1ns / 1ps

module fvcw_front
    import fvcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic vec_valid,
    input  vec_t vec,
    output logic dout_valid,
    output div_t dout
);

    // Stage 1: magnitudes and signs of the negated vector
    logic             s1_valid_reg;
    logic [MAG_W-1:0] ax_reg, ay_reg;
    logic             xneg_reg, yneg_reg;
    logic [MAG_W-1:0] ax_next, ay_next;
    logic             xneg_next, yneg_next;

    // Stage 2: denominator, wheel numerator, radius
    logic             s2_valid_reg;
    logic [D_W-1:0]   d_reg;
    logic [T_W-1:0]   t_reg;
    logic [RAD_W-1:0] rad_reg;
    logic             near_reg, zero_reg;
    logic [D_W-1:0]   d_next;
    logic [T_W-1:0]   t_next, two_d, num;
    logic [MAG_W-1:0] rad_full;
    logic             near_next;

    // Stage 3: scaled dividend loaded into the divider lane
    logic             s3_valid_reg;
    div_t             s3_reg;
    div_t             s3_next;
    logic [SCALE_W-1:0] scaled;
    logic [N_W-1:0]   numer;

    // Take magnitudes; x = -flow_x and y = -flow_y
    always_comb
    begin
        ax_next   = vec.flow_x[IN_W-1] ? MAG_W'(-vec.flow_x) : MAG_W'(vec.flow_x);
        ay_next   = vec.flow_y[IN_W-1] ? MAG_W'(-vec.flow_y) : MAG_W'(vec.flow_y);
        xneg_next = !vec.flow_x[IN_W-1] && (vec.flow_x != '0);
        yneg_next = !vec.flow_y[IN_W-1] && (vec.flow_y != '0);
    end

    // Form D, the numerator 2D +- Num and the radius
    always_comb
    begin
        d_next    = D_W'(ax_reg) + D_W'(ay_reg);
        two_d     = T_W'({d_next, 1'b0});
        num       = xneg_reg ? (T_W'(ay_reg) + T_W'({ax_reg, 1'b0})) : T_W'(ay_reg);
        t_next    = yneg_reg ? (two_d - num) : (two_d + num);
        rad_full  = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        near_next = (rad_full <= ONE);
    end

    // Scale by the wheel span and split the dividend into remainder and low bits
    always_comb
    begin
        scaled       = SCALE_W'(t_reg) * SCALE_W'(WHEEL_SIZE - 1);
        numer        = {scaled, (POS_FRAC - 2)'(0)};
        s3_next.rem  = numer[N_W-1:Q_W];
        s3_next.bits = numer[Q_W-1:0];
        s3_next.den  = d_reg;
        s3_next.rad  = rad_reg;
        s3_next.near = near_reg;
        s3_next.zero = zero_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= vec_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            xneg_reg <= xneg_next;
            yneg_reg <= yneg_next;
            d_reg    <= d_next;
            t_reg    <= t_next;
            rad_reg  <= near_next ? rad_full[RAD_W-1:0] : '0;
            near_reg <= near_next;
            zero_reg <= (d_next == '0);
            s3_reg   <= s3_next;
        end
    end

    assign dout_valid = s3_valid_reg;
    assign dout       = s3_reg;

    // The dividend head must already sit below the divisor
    a_head_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_reg.zero |-> s3_reg.rem < s3_reg.den)
        else $error("divider head not below divisor");

endmodule

// File: sv/fvcw_div.sv
`timescale 1ns / 1ps

module fvcw_div
    import fvcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic din_valid,
    input  div_t din,
    output logic dout_valid,
    output div_t dout
);

    // One restoring step: bring down the next dividend bit, subtract if it fits
    function automatic div_t div_step(input div_t s);
        div_t           r;
        logic [D_W:0]   part;
        logic [D_W:0]   trial;
        r     = s;
        part  = {s.rem, s.bits[Q_W-1]};
        trial = part - {1'b0, s.den};
        if (part >= {1'b0, s.den})
        begin
            r.rem  = trial[D_W-1:0];
            r.bits = {s.bits[Q_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = part[D_W-1:0];
            r.bits = {s.bits[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    div_t           st_reg  [Q_W];
    div_t           st_next [Q_W];
    logic [Q_W-1:0] vld_reg;

    // Chain one quotient bit per stage
    for (genvar i = 0; i < Q_W; i++)
    begin : g_step
        if (i == 0)
        begin : g_first
            assign st_next[i] = div_step(din);
        end
        else
        begin : g_rest
            assign st_next[i] = div_step(st_reg[i-1]);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[Q_W-2:0], din_valid};
        end
    end

    // Advance lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    assign dout_valid = vld_reg[Q_W-1];
    assign dout       = st_reg[Q_W-1];

    // Final remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout.zero |-> dout.rem < dout.den)
        else $error("divider remainder not below divisor");

    // Quotient never runs past the last wheel entry
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout.zero |-> dout.bits <= MAX_POS)
        else $error("wheel position out of range");

endmodule

// File: sv/fvcw_shade.sv
`timescale 1ns / 1ps

module fvcw_shade
    import fvcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic din_valid,
    input  div_t din,
    output logic pix_valid,
    output pix_t pix
);

    localparam int ILP_W = CH_W + POS_FRAC + 2;
    localparam logic [PROD_W-1:0] WHITE_FULL = PROD_W'(WHITE) << FRAC_BITS;

    // Stage A: wheel lookup
    logic                a_valid_reg;
    color_t              c0_reg, c1_reg;
    logic [POS_FRAC-1:0] f_reg;
    logic [RAD_W-1:0]    rad_a_reg;
    logic                near_a_reg;
    logic [Q_W-1:0]      pos;
    logic [WIDX_W-1:0]   k0, k1;

    // Stage B: interpolated channels
    logic                b_valid_reg;
    logic [CQ_W-1:0]     cq_reg  [3];
    logic [CQ_W-1:0]     cq_next [3];
    logic [RAD_W-1:0]    rad_b_reg;
    logic                near_b_reg;

    // Stage C: blended output bytes
    logic                c_valid_reg;
    pix_t                pix_reg;
    logic [2:0][CH_W-1:0] res;

    // Pick the wheel position and its neighbor, wrapping at the last entry
    always_comb
    begin
        pos = din.zero ? MID_POS : din.bits;
        k0  = pos[Q_W-1:POS_FRAC];
        if (k0 > WIDX_W'(WHEEL_SIZE - 1))
        begin
            k0 = WIDX_W'(WHEEL_SIZE - 1);
        end
        k1 = (k0 == WIDX_W'(WHEEL_SIZE - 1)) ? '0 : k0 + 1'b1;
    end

    // Interpolate each channel as c0 + (c1 - c0) * f
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic signed [CH_W:0]     diff;
            logic signed [POS_FRAC:0] fext;
            logic signed [ILP_W-1:0]  prod;
            logic signed [ILP_W-1:0]  base;
            logic signed [ILP_W-1:0]  sum;
            diff = $signed({1'b0, c1_reg[ch]}) - $signed({1'b0, c0_reg[ch]});
            fext = $signed({1'b0, f_reg});
            prod = diff * fext;
            base = $signed(ILP_W'({c0_reg[ch], POS_FRAC'(0)}));
            sum  = base + prod;
            cq_next[ch] = sum[CQ_W-1:0];
        end
    end

    // Blend toward white inside the unit radius, dim by 3/4 outside
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [CQ_W-1:0]   gap;
            logic [PROD_W-1:0] blend;
            logic [PROD_W-1:0] v;
            logic [CQ_W+1:0]   m3;
            gap   = WHITE - cq_reg[ch];
            blend = PROD_W'(rad_b_reg) * PROD_W'(gap);
            v     = WHITE_FULL - blend;
            m3    = (CQ_W + 2)'({cq_reg[ch], 1'b0}) + (CQ_W + 2)'(cq_reg[ch]);
            res[ch] = near_b_reg ? v[POS_FRAC+FRAC_BITS +: CH_W] : m3[POS_FRAC+2 +: CH_W];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= din_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Advance payload; wheel rows are red, green, blue
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg        <= wheel_color(k0);
            c1_reg        <= wheel_color(k1);
            f_reg         <= pos[POS_FRAC-1:0];
            rad_a_reg     <= din.rad;
            near_a_reg    <= din.near;
            cq_reg        <= cq_next;
            rad_b_reg     <= rad_a_reg;
            near_b_reg    <= near_a_reg;
            pix_reg.red   <= res[2];
            pix_reg.green <= res[1];
            pix_reg.blue  <= res[0];
        end
    end

    assign pix_valid = c_valid_reg;
    assign pix       = pix_reg;

    // Interpolated channels never exceed full scale
    a_cq_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (cq_reg[0] <= WHITE) && (cq_reg[1] <= WHITE) && (cq_reg[2] <= WHITE))
        else $error("interpolated channel above full scale");

endmodule

// File: sv/flow_vector_color_wheel_top.sv
`timescale 1ns / 1ps

// Flow vector color wheel: one 2-D vector in, one color pixel out.
// Input channel vec_valid / vec_ready / vec carries flow_x and flow_y, signed
// with FRAC_BITS fraction bits. Output channel pix_valid / pix_ready / pix
// carries the blue, green and red bytes. A transaction moves on a channel at
// a rising edge where its valid and ready are both high.
// Throughput: one vector per clock while pix_ready stays high.
// An input transaction reaches pix_valid through magnitude and numerator
// setup, the one-bit-per-stage wheel position divider, and wheel lookup,
// interpolation and radius blending.
// The whole pipeline advances as one; when the receiver holds pix_ready low
// with a pixel waiting, every stage holds and vec_ready drops in the same
// cycle, so nothing is lost or repeated. Empty stages are not squeezed out.
// Reset (rst_n low, asynchronous) clears all stage valid bits; the pipeline
// comes up empty and accepts a vector in the first cycle after release.
module flow_vector_color_wheel_top
    import fvcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic vec_valid,
    output logic vec_ready,
    input  vec_t vec,
    output logic pix_valid,
    input  logic pix_ready,
    output pix_t pix
);

    logic adv;
    logic front_valid, div_valid;
    div_t front_data, div_data;

    // Advance the pipeline whenever the output register is free or being drained
    assign adv       = !pix_valid || pix_ready;
    assign vec_ready = adv;

    fvcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .vec_valid  (vec_valid),
        .vec        (vec),
        .dout_valid (front_valid),
        .dout       (front_data)
    );

    fvcw_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .din_valid  (front_valid),
        .din        (front_data),
        .dout_valid (div_valid),
        .dout       (div_data)
    );

    fvcw_shade u_shade (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .din_valid  (div_valid),
        .din        (div_data),
        .pix_valid  (pix_valid),
        .pix        (pix)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fvcw_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int SHOW_LIMIT  = 10;
    localparam longint unsigned UNIT_RADIUS = 64'd1 << FRAC_BITS;
    localparam longint unsigned FRAC_ONE    = 64'd1 << POS_FRAC;
    localparam longint unsigned WHITE_Q     = 64'd255 << POS_FRAC;

    // Hue wheel, one 24-bit word per entry: red [23:16], green [15:8], blue [7:0]
    localparam logic [23:0] HUE_WHEEL [WHEEL_SIZE] = '{
        24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400,
        24'hFF5500, 24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900,
        24'hFFAA00, 24'hFFBB00, 24'hFFCC00, 24'hFFDD00, 24'hFFEE00,
        24'hFFFF00, 24'hD5FF00, 24'hAAFF00, 24'h80FF00, 24'h55FF00,
        24'h2BFF00,
        24'h00FF00, 24'h00FF3F, 24'h00FF7F, 24'h00FFBF,
        24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF,
        24'h008CFF, 24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF,
        24'h0018FF,
        24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF,
        24'h6200FF, 24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF,
        24'hC400FF, 24'hD700FF, 24'hEB00FF,
        24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055,
        24'hFF002B
    };

    typedef struct {
        vec_t vin;
        pix_t color;
    } pending_pixel_t;

    logic clk;
    logic rst_n;
    logic vec_valid;
    logic vec_ready;
    vec_t vec;
    logic pix_valid;
    logic pix_ready;
    pix_t pix;

    pending_pixel_t pending_pixels [$];
    pending_pixel_t oldest;
    int failures;
    int vectors_sent;
    int pixels_checked;
    int idle_cycles;
    bit tx_gaps;
    bit rx_stalls;
    int rx_stall_pct;

    flow_vector_color_wheel_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vec_valid (vec_valid),
        .vec_ready (vec_ready),
        .vec       (vec),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Compute the pixel color for one flow vector
    function automatic pix_t wheel_pixel(vec_t v);
        int x;
        int y;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned rad;
        longint unsigned d;
        longint unsigned num;
        longint unsigned t;
        longint unsigned pos;
        longint unsigned f;
        longint unsigned c0;
        longint unsigned c1;
        longint unsigned cq;
        longint unsigned res;
        int k0;
        int k1;
        logic [7:0] chan [3];
        pix_t p;
        x = -int'($signed(v.flow_x));
        y = -int'($signed(v.flow_y));
        ax = (x < 0) ? longint'(-x) : longint'(x);
        ay = (y < 0) ? longint'(-y) : longint'(y);
        rad = (ax > ay) ? ax : ay;
        if (ax == 0 && ay == 0)
        begin
            // zero vector sits at the middle of the wheel
            pos = (longint'(WHEEL_SIZE - 1) << POS_FRAC) >> 1;
        end
        else
        begin
            d = ax + ay;
            num = (x >= 0) ? ay : ay + 2 * ax;
            t = (y < 0) ? (2 * d - num) : (2 * d + num);
            pos = ((longint'(WHEEL_SIZE - 1) * t) << POS_FRAC) / (4 * d);
        end
        k0 = int'(pos >> POS_FRAC);
        if (k0 >= WHEEL_SIZE)
        begin
            k0 = WHEEL_SIZE - 1;
        end
        f = pos & (FRAC_ONE - 1);
        k1 = (k0 + 1) % WHEEL_SIZE;
        for (int ch = 0; ch < 3; ch++)
        begin
            c0 = longint'((HUE_WHEEL[k0] >> (16 - 8 * ch)) & 24'hFF);
            c1 = longint'((HUE_WHEEL[k1] >> (16 - 8 * ch)) & 24'hFF);
            cq = c0 * (FRAC_ONE - f) + c1 * f;
            if (rad <= UNIT_RADIUS)
            begin
                // blend toward white by radius
                res = ((WHITE_Q << FRAC_BITS) - rad * (WHITE_Q - cq))
                      >> (POS_FRAC + FRAC_BITS);
            end
            else
            begin
                // dim by three quarters
                res = (cq * 3) >> (POS_FRAC + 2);
            end
            chan[ch] = res[7:0];
        end
        p.red   = chan[0];
        p.green = chan[1];
        p.blue  = chan[2];
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 50);
    endfunction

    function automatic logic [15:0] pick_component(int mode);
        logic [15:0] corners [9];
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF,
                    16'h4000, 16'hC000, 16'h4001, 16'hBFFF};
        case (mode)
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 32768)) - 16384);
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            3: return 16'(int'($urandom_range(16380, 16388))
                          * (($urandom_range(0, 1) != 0) ? 1 : -1));
            default: return corners[$urandom_range(0, 8)];
        endcase
    endfunction

    // Mostly unit-circle and full-range vectors, with axes and corners mixed in
    function automatic vec_t random_vector();
        vec_t v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            v.flow_x = pick_component(0);
            v.flow_y = pick_component(0);
        end
        else if (r < 65)
        begin
            v.flow_x = pick_component(1);
            v.flow_y = pick_component(1);
        end
        else if (r < 75)
        begin
            v.flow_x = pick_component(2);
            v.flow_y = pick_component(2);
        end
        else if (r < 83)
        begin
            v.flow_x = pick_component(3);
            v.flow_y = pick_component(1);
        end
        else if (r < 91)
        begin
            // one component zero
            v.flow_x = ($urandom_range(0, 1) != 0) ? pick_component(0) : 16'h0000;
            v.flow_y = (v.flow_x == 16'h0000) ? pick_component(0) : 16'h0000;
        end
        else
        begin
            v.flow_x = pick_component(4);
            v.flow_y = pick_component(4);
        end
        return v;
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= SHOW_LIMIT)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // Send one vector transaction and record its expected pixel
    task automatic send_vector(input logic [15:0] fx, input logic [15:0] fy);
        int gap;
        pending_pixel_t item;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            vec_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        vec.flow_x = fx;
        vec.flow_y = fy;
        vec_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!vec_ready);
        item.vin = vec;
        item.color = wheel_pixel(vec);
        pending_pixels.insert(pending_pixels.size(), item);
        vectors_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every pending pixel has come out
    task automatic wait_drained();
        vec_valid = 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_random(input int count, input int drain_every);
        vec_t v;
        for (int i = 0; i < count; i++)
        begin
            v = random_vector();
            send_vector(v.flow_x, v.flow_y);
            if (drain_every > 0 && (i % drain_every) == drain_every - 1)
            begin
                wait_drained();
            end
        end
    endtask

    task automatic test_corner_vectors();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        rx_stall_pct = 20;
        // zero vector, then each axis at the unit radius and at full scale
        send_vector(16'h0000, 16'h0000);
        send_vector(16'h4000, 16'h0000);
        send_vector(16'hC000, 16'h0000);
        send_vector(16'h0000, 16'h4000);
        send_vector(16'h0000, 16'hC000);
        send_vector(16'h7FFF, 16'h0000);
        send_vector(16'h8000, 16'h0000);
        send_vector(16'h0000, 16'h7FFF);
        send_vector(16'h0000, 16'h8000);
        // just outside the unit radius
        send_vector(16'h4001, 16'h0000);
        send_vector(16'h0000, 16'hBFFF);
        // diagonals and extreme corners
        send_vector(16'h4000, 16'h4000);
        send_vector(16'hC000, 16'h4000);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7FFF, 16'h7FFF);
        send_vector(16'h8000, 16'h7FFF);
        send_vector(16'h7FFF, 16'h8000);
        // last wheel entry wraps to the first; just below the wrap
        send_vector(16'd100, 16'h0000);
        send_vector(16'd30000, 16'hFFFF);
        // near the start of the wheel
        send_vector(16'd20000, 16'h0001);
        // tiny vectors
        send_vector(16'h0001, 16'h0000);
        send_vector(16'hFFFF, 16'hFFFF);
        send_vector(16'h0000, 16'h0001);
        wait_drained();
    endtask

    task automatic test_full_rate();
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        send_random(120, 0);
        wait_drained();
    endtask

    task automatic test_random_flow();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        rx_stall_pct = 25;
        send_random(250, 60);
        wait_drained();
    endtask

    task automatic test_heavy_backpressure();
        tx_gaps = 1'b0;
        rx_stalls = 1'b1;
        rx_stall_pct = 60;
        send_random(80, 0);
        wait_drained();
    endtask

    // Receiver: hold ready high, drop it for random stretches when enabled
    initial
    begin
        pix_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_stalls && $urandom_range(0, 99) < rx_stall_pct)
            begin
                pix_ready = 1'b0;
                repeat (pick_gap() + 1) @(negedge clk);
            end
            pix_ready = 1'b1;
        end
    end

    // Compare each pixel transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && pix_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_failure($sformatf("unexpected pixel b/g/r %0d/%0d/%0d",
                                         pix.blue, pix.green, pix.red));
            end
            else
            begin
                oldest = pending_pixels.pop_front();
                if (pix.blue !== oldest.color.blue || pix.green !== oldest.color.green ||
                    pix.red !== oldest.color.red)
                begin
                    report_failure($sformatf(
                        "pixel %0d for (%0d,%0d): expected b/g/r %0d/%0d/%0d, got %0d/%0d/%0d",
                        pixels_checked, oldest.vin.flow_x, oldest.vin.flow_y,
                        oldest.color.blue, oldest.color.green, oldest.color.red,
                        pix.blue, pix.green, pix.red));
                end
                pixels_checked++;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vec_valid && vec_ready) || (pix_valid && pix_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("Timeout after %0d idle cycles", idle_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        vec_valid = 1'b0;
        vec = '0;
        failures = 0;
        vectors_sent = 0;
        pixels_checked = 0;
        idle_cycles = 0;
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        rx_stall_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_corner_vectors();
        test_full_rate();
        test_random_flow();
        test_heavy_backpressure();

        // let any stray pixel show up before the final check
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            report_failure($sformatf("%0d pixels never arrived", pending_pixels.size()));
        end

        $display("Sent %0d vectors, checked %0d pixels, %0d failures", vectors_sent,
                 pixels_checked, failures);
        $display("Covered axes, corners, wheel wrap, unit-radius edge, full rate and stalls");
        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/fvcw_pkg.sv
sv/fvcw_front.sv
sv/fvcw_div.sv
sv/fvcw_shade.sv
sv/flow_vector_color_wheel_top.sv
bench/testbench.sv
